// ===== hw/rtl/mpl_parser_pkg.sv =====
`timescale 1ns / 1ps

package mpl_parser_pkg;

	// Default limit on the declared response length, in bytes.
	localparam int BUFFER_BYTES_DEF = 256;

	localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
	localparam logic [16:0] HDR_BYTES   = 17'd8;
	localparam logic [5:0]  FLEX_CODE   = 6'd5;
	localparam logic [7:0]  MIN_FLEX_LEN = 8'd30;

	// Header byte positions.
	localparam logic [16:0] POS_MDL_HI  = 17'd0;
	localparam logic [16:0] POS_MDL_LO  = 17'd1;
	localparam logic [16:0] POS_DESC_HI = 17'd6;
	localparam logic [16:0] POS_DESC_LO = 17'd7;

	// Offsets of the captured fields inside the flexible disk page.
	localparam logic [4:0] REL_RATE_HI = 5'd2;
	localparam logic [4:0] REL_RATE_LO = 5'd3;
	localparam logic [4:0] REL_HEADS   = 5'd4;
	localparam logic [4:0] REL_SPT     = 5'd5;
	localparam logic [4:0] REL_SECT_HI = 5'd6;
	localparam logic [4:0] REL_SECT_LO = 5'd7;
	localparam logic [4:0] REL_CYL_HI  = 5'd8;
	localparam logic [4:0] REL_CYL_LO  = 5'd9;
	localparam logic [4:0] REL_ROT_HI  = 5'd28;
	localparam logic [4:0] REL_ROT_LO  = 5'd29;
	localparam logic [16:0] REL_LAST   = 17'd29;

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_SEEK      = 3'd1,
		PH_OTHER_LEN = 3'd2,
		PH_FLEX_LEN  = 3'd3,
		PH_CAPTURE   = 3'd4,
		PH_STOP      = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_SHORT_HDR    = 4'd1,
		ST_BAD_LEN      = 4'd2,
		ST_DESC_OVERRUN = 4'd3,
		ST_PAGE_HDR_CUT = 4'd4,
		ST_RSVD_BIT     = 4'd5,
		ST_PAGE_CUT     = 4'd6,
		ST_PAGE_SHORT   = 4'd7,
		ST_NO_PAGE      = 4'd8
	} status_t;

	// Result word, lowest field last so that it lands in the lowest bits.
	typedef struct packed {
		logic [3:0]  pad;
		logic [15:0] rotation_rate;
		logic [15:0] cylinder_count;
		logic [15:0] sector_bytes;
		logic [7:0]  track_sectors;
		logic [7:0]  head_count;
		logic [15:0] data_rate;
		logic [15:0] page_start;
		status_t     status;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		status_t     err;
		logic [16:0] next_start;
	} page_step_t;

	// Decide where the walk goes at a new page position.
	function automatic page_step_t enter_page(input logic [16:0] pos,
		input logic [16:0] decl, input status_t err_in);
		page_step_t r;
		r.next_start = pos;
		r.err = err_in;
		if (pos >= decl) begin
			r.err = ST_NO_PAGE;
			r.phase = PH_STOP;
		end else if ((decl - pos) < 17'd2) begin
			r.err = ST_PAGE_HDR_CUT;
			r.phase = PH_STOP;
		end else begin
			r.phase = PH_SEEK;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/mode_page_list_parser_core.sv =====
`timescale 1ns / 1ps

// MODE SENSE (10) response parser. Response bytes stream in one word per
// cycle on the slave side, with tlast on the final byte. The 8-byte header
// supplies the mode data length and the block descriptor length; the page
// headers after the descriptors are then walked until the first flexible
// disk page (code 5), whose geometry fields are captured. After the final
// byte one result word leaves on the master side with a status code, the
// page offset and the geometry (all zero unless the status is ok), and the
// parser is ready for the next response at once. Each byte sits in the
// input register, and its compares and counter updates finish before the
// next byte, so a new word is accepted in every cycle. Only a final byte
// waits, and only while a previous result word is still held by the output
// register.

module mode_page_list_parser_core #(
	parameter int BUFFER_BYTES = mpl_parser_pkg::BUFFER_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [3:0] status, [19:4] page_start, [35:20] data_rate,
	// [43:36] head_count, [51:44] track_sectors, [67:52] sector_bytes,
	// [83:68] cylinder_count, [99:84] rotation_rate, [103:100] zero
	output logic [103:0] m_axis_tdata
);

	localparam logic [16:0] BufLimit = 17'(BUFFER_BYTES);

	// Input register.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;

	// Walk state.
	logic [16:0]          byte_count_q;
	logic [15:0]          mdl_q;
	logic [15:0]          desc_q;
	logic [16:0]          next_start_q;
	logic [16:0]          cur_start_q;
	mpl_parser_pkg::phase_t  phase_q;
	mpl_parser_pkg::status_t err_q;
	logic [15:0]          rate_q;
	logic [7:0]           heads_q;
	logic [7:0]           spt_q;
	logic [15:0]          sect_q;
	logic [15:0]          cyl_q;
	logic [15:0]          rot_q;

	// Next-state values.
	logic [15:0]          nx_mdl;
	logic [15:0]          nx_desc;
	logic [16:0]          nx_next_start;
	logic [16:0]          nx_cur_start;
	mpl_parser_pkg::phase_t  nx_phase;
	mpl_parser_pkg::status_t nx_err;
	logic [15:0]          nx_rate;
	logic [7:0]           nx_heads;
	logic [7:0]           nx_spt;
	logic [15:0]          nx_sect;
	logic [15:0]          nx_cyl;
	logic [15:0]          nx_rot;
	mpl_parser_pkg::result_t nx_result;

	// Output register.
	logic                    out_valid_q;
	mpl_parser_pkg::result_t result_q;

	// A byte may leave the input register unless it is a final byte and
	// the previous result word has not been taken yet.
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Per-byte walk: header capture, page header walk, geometry capture,
	// and the final status, all from the state left by the previous byte.
	always_comb begin
		logic [16:0] p;
		logic [16:0] decl;
		logic [16:0] plen;
		logic [16:0] rel;
		logic [17:0] len;
		mpl_parser_pkg::page_step_t step;
		mpl_parser_pkg::status_t st;

		p    = byte_count_q;
		decl = {1'b0, mdl_q} + 17'd2;
		plen = {9'd0, data_s1} + 17'd2;
		rel  = p - cur_start_q;
		len  = {1'b0, p} + 18'd1;
		step = '0;

		nx_mdl        = mdl_q;
		nx_desc       = desc_q;
		nx_next_start = next_start_q;
		nx_cur_start  = cur_start_q;
		nx_phase      = phase_q;
		nx_err        = err_q;
		nx_rate       = rate_q;
		nx_heads      = heads_q;
		nx_spt        = spt_q;
		nx_sect       = sect_q;
		nx_cyl        = cyl_q;
		nx_rot        = rot_q;

		unique case (phase_q)
			mpl_parser_pkg::PH_HEADER: begin
				if (p == mpl_parser_pkg::POS_MDL_HI) begin
					nx_mdl[15:8] = data_s1;
				end else if (p == mpl_parser_pkg::POS_MDL_LO) begin
					nx_mdl[7:0] = data_s1;
				end else if (p == mpl_parser_pkg::POS_DESC_HI) begin
					nx_desc[15:8] = data_s1;
				end else if (p == mpl_parser_pkg::POS_DESC_LO) begin
					nx_desc[7:0] = data_s1;
					step = mpl_parser_pkg::enter_page(
						mpl_parser_pkg::HDR_BYTES + {1'b0, desc_q[15:8], data_s1},
						decl, err_q);
					nx_phase      = step.phase;
					nx_err        = step.err;
					nx_next_start = step.next_start;
				end
			end
			mpl_parser_pkg::PH_SEEK: begin
				if (p == next_start_q) begin
					nx_cur_start = p;
					if (data_s1[6]) begin
						nx_err   = mpl_parser_pkg::ST_RSVD_BIT;
						nx_phase = mpl_parser_pkg::PH_STOP;
					end else if (data_s1[5:0] == mpl_parser_pkg::FLEX_CODE) begin
						nx_phase = mpl_parser_pkg::PH_FLEX_LEN;
					end else begin
						nx_phase = mpl_parser_pkg::PH_OTHER_LEN;
					end
				end
			end
			mpl_parser_pkg::PH_OTHER_LEN, mpl_parser_pkg::PH_FLEX_LEN: begin
				if (p == cur_start_q + 17'd1) begin
					if (plen > decl - cur_start_q) begin
						nx_err   = mpl_parser_pkg::ST_PAGE_CUT;
						nx_phase = mpl_parser_pkg::PH_STOP;
					end else if (phase_q == mpl_parser_pkg::PH_FLEX_LEN) begin
						if (data_s1 < mpl_parser_pkg::MIN_FLEX_LEN) begin
							nx_err   = mpl_parser_pkg::ST_PAGE_SHORT;
							nx_phase = mpl_parser_pkg::PH_STOP;
						end else begin
							nx_phase = mpl_parser_pkg::PH_CAPTURE;
						end
					end else begin
						step = mpl_parser_pkg::enter_page(cur_start_q + plen, decl, err_q);
						nx_phase      = step.phase;
						nx_err        = step.err;
						nx_next_start = step.next_start;
					end
				end
			end
			mpl_parser_pkg::PH_CAPTURE: begin
				if (rel <= mpl_parser_pkg::REL_LAST) begin
					case (rel[4:0])
						mpl_parser_pkg::REL_RATE_HI: nx_rate[15:8] = data_s1;
						mpl_parser_pkg::REL_RATE_LO: nx_rate[7:0]  = data_s1;
						mpl_parser_pkg::REL_HEADS:   nx_heads      = data_s1;
						mpl_parser_pkg::REL_SPT:     nx_spt        = data_s1;
						mpl_parser_pkg::REL_SECT_HI: nx_sect[15:8] = data_s1;
						mpl_parser_pkg::REL_SECT_LO: nx_sect[7:0]  = data_s1;
						mpl_parser_pkg::REL_CYL_HI:  nx_cyl[15:8]  = data_s1;
						mpl_parser_pkg::REL_CYL_LO:  nx_cyl[7:0]   = data_s1;
						mpl_parser_pkg::REL_ROT_HI:  nx_rot[15:8]  = data_s1;
						mpl_parser_pkg::REL_ROT_LO:  nx_rot[7:0]   = data_s1;
						default: ;
					endcase
				end
			end
			mpl_parser_pkg::PH_STOP: ;
			default: ;
		endcase

		// Final status, checked in order of precedence.
		if (len < {1'b0, mpl_parser_pkg::HDR_BYTES}) begin
			st = mpl_parser_pkg::ST_SHORT_HDR;
		end else if (decl < mpl_parser_pkg::HDR_BYTES || {1'b0, decl} > len ||
				decl > BufLimit) begin
			st = mpl_parser_pkg::ST_BAD_LEN;
		end else if (mpl_parser_pkg::HDR_BYTES + {1'b0, nx_desc} > decl) begin
			st = mpl_parser_pkg::ST_DESC_OVERRUN;
		end else if (nx_phase == mpl_parser_pkg::PH_CAPTURE) begin
			st = mpl_parser_pkg::ST_OK;
		end else if (nx_err != mpl_parser_pkg::ST_OK) begin
			st = nx_err;
		end else begin
			st = mpl_parser_pkg::ST_NO_PAGE;
		end

		nx_result = '0;
		nx_result.status = st;
		if (st == mpl_parser_pkg::ST_OK) begin
			nx_result.page_start     = nx_cur_start[15:0];
			nx_result.data_rate      = nx_rate;
			nx_result.head_count     = nx_heads;
			nx_result.track_sectors  = nx_spt;
			nx_result.sector_bytes   = nx_sect;
			nx_result.cylinder_count = nx_cyl;
			nx_result.rotation_rate  = nx_rot;
		end
	end

	// Walk state; a final byte returns everything to the start of a response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			mdl_q        <= '0;
			desc_q       <= '0;
			next_start_q <= '0;
			cur_start_q  <= '0;
			phase_q      <= mpl_parser_pkg::PH_HEADER;
			err_q        <= mpl_parser_pkg::ST_OK;
			rate_q       <= '0;
			heads_q      <= '0;
			spt_q        <= '0;
			sect_q       <= '0;
			cyl_q        <= '0;
			rot_q        <= '0;
		end else if (advance) begin
			if (last_s1) begin
				byte_count_q <= '0;
				mdl_q        <= '0;
				desc_q       <= '0;
				next_start_q <= '0;
				cur_start_q  <= '0;
				phase_q      <= mpl_parser_pkg::PH_HEADER;
				err_q        <= mpl_parser_pkg::ST_OK;
				rate_q       <= '0;
				heads_q      <= '0;
				spt_q        <= '0;
				sect_q       <= '0;
				cyl_q        <= '0;
				rot_q        <= '0;
			end else begin
				if (byte_count_q != mpl_parser_pkg::COUNT_MAX) begin
					byte_count_q <= byte_count_q + 17'd1;
				end
				mdl_q        <= nx_mdl;
				desc_q       <= nx_desc;
				next_start_q <= nx_next_start;
				cur_start_q  <= nx_cur_start;
				phase_q      <= nx_phase;
				err_q        <= nx_err;
				rate_q       <= nx_rate;
				heads_q      <= nx_heads;
				spt_q        <= nx_spt;
				sect_q       <= nx_sect;
				cyl_q        <= nx_cyl;
				rot_q        <= nx_rot;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= nx_result;
		end
	end

	// A failed response carries no page offset and no geometry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status != mpl_parser_pkg::ST_OK |->
			result_q.page_start == '0 && result_q.data_rate == '0 &&
			result_q.rotation_rate == '0 && result_q.cylinder_count == '0)
		else $error("failed result carries geometry");

	// A good page always lies after the 8-byte header.
	a_ok_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status == mpl_parser_pkg::ST_OK |->
			{1'b0, result_q.page_start} >= mpl_parser_pkg::HDR_BYTES)
		else $error("good page offset inside header");

	// The final byte leaves the walk back at the start of a response.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=>
			byte_count_q == '0 && phase_q == mpl_parser_pkg::PH_HEADER &&
			err_q == mpl_parser_pkg::ST_OK)
		else $error("walk not restarted after final byte");

	// Capture only runs once the page length byte has gone by.
	a_capture_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mpl_parser_pkg::PH_CAPTURE |->
			{1'b0, byte_count_q} >= {1'b0, cur_start_q} + 18'd2)
		else $error("capture before page length byte");

endmodule
